// ===== rtl/llds_pkg.sv =====
package llds_pkg;

    // defaults for the top-level parameters
    localparam int APPROX_WIDTH_DEF = 32;
    localparam int OUT_WIDTH_DEF    = 48;

    // fixed field widths
    localparam int TARGET_W   = 17;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 2;

    // register map
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_EXP_DOMAIN = 2'd0,
        REG_USE_DELTA  = 2'd1,
        REG_USE_WEIGHT = 2'd2,
        REG_DER_ORDER  = 2'd3
    } t_cfg_reg;

    localparam logic [1:0] ORDER_TWO   = 2'd2;
    localparam logic [1:0] ORDER_THREE = 2'd3;

    // internal widths
    localparam int X_W   = 43;  // clamped log argument sum
    localparam int A_W   = 29;  // |x| below the underflow limit
    localparam int E_W   = 46;  // exp-mode product
    localparam int N_W   = 6;   // ln2 multiple count
    localparam int R_W   = 32;  // reduced argument, Q.32
    localparam int S_W   = 33;  // series value, Q.32 up to 1.0
    localparam int DEN_W = 47;
    localparam int NUM_W = 57;
    localparam int Q_W   = 25;
    localparam int P_W   = 25;  // probability, Q.24 up to 1.0

    localparam logic [S_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [P_W-1:0] ONE_Q24 = 25'h100_0000;
    localparam logic [31:0]    LN2_Q32 = 32'd2977044472;
    // floor(2^63 / ln2_q32): n = (a * INV_LN2) >> INV_SHIFT, low by at most one
    localparam logic [63:0]    INV_LN2_FULL = 64'h8000_0000_0000_0000 / 64'd2977044472;
    localparam logic [31:0]    INV_LN2   = INV_LN2_FULL[31:0];
    localparam int             INV_SHIFT = 55;
    // exp(-a) reads as zero from 23.0 up
    localparam logic [X_W-1:0] BIG_LIMIT = 43'd385875968;

    localparam int SERIES_TERMS = 10;

    localparam int FRONT_STAGES = 4;
    localparam int STEP_STAGES  = 3;
    localparam int PROB_STAGES  = Q_W + 2;
    localparam int DER_STAGES   = 4;
    localparam int LATENCY      = FRONT_STAGES + SERIES_TERMS * STEP_STAGES
                                  + PROB_STAGES + DER_STAGES;

    typedef struct packed {
        logic                use_weight;
        logic                use_delta;
        logic                exp_domain;
        logic [1:0]          order;
    } t_cfg;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
        logic                pos;
        logic                big;
        logic                expm;
        logic [E_W-1:0]      e;
    } t_side;

    typedef struct packed {
        logic [R_W-1:0]      r;
        logic [S_W-1:0]      s;
        logic [N_W-1:0]      n;
        t_side               side;
    } t_ser;

    typedef struct packed {
        logic [P_W-1:0]      p;
        logic [TARGET_W-1:0] target;
        logic [WEIGHT_W-1:0] weight;
        logic                last;
    } t_prob;

endpackage

// ===== rtl/logistic_loss_derivative_stream.sv =====
// Logistic loss derivative stream.
// Input: pulse i_start with a sample (i_approx, i_approx_delta, i_target,
// i_weight, i_last_in_range); the beat is taken when i_start is high and
// o_busy is low. o_busy is high only during reset and the cycle after it.
// Output: o_done strobes for one cycle with o_first_der, o_second_der,
// o_third_der and o_last_of_range; the receiver cannot hold results off.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_addr
// (0 exp_domain, 1 use_delta, 2 use_weight, 3 derivative_order); write
// only while no sample is in flight.
// Throughput: one sample per cycle, every cycle.
// Pipeline: from the accepting edge to the result strobe, a sample passes
// 4 front-end stages (clamp, |x|, ln2 range reduction), 10 series terms of
// 3 stages each for exp(-r), 27 stages of the radix-2 divider for p, and
// 4 derivative stages (products, masking, weighting, saturation).
// Reset: clears the pipeline valid bits and the config registers
// (order = 2, all flags 0). No clearing pass.
module logistic_loss_derivative_stream #(
    parameter int APPROX_WIDTH = llds_pkg::APPROX_WIDTH_DEF,
    parameter int OUT_WIDTH    = llds_pkg::OUT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic signed [APPROX_WIDTH-1:0]      i_approx,
    input  logic signed [APPROX_WIDTH-1:0]      i_approx_delta,
    input  logic [llds_pkg::TARGET_W-1:0]       i_target,
    input  logic [llds_pkg::WEIGHT_W-1:0]       i_weight,
    input  logic                                i_last_in_range,
    output logic                                o_done,
    output logic signed [OUT_WIDTH-1:0]         o_first_der,
    output logic signed [OUT_WIDTH-1:0]         o_second_der,
    output logic signed [OUT_WIDTH-1:0]         o_third_der,
    output logic                                o_last_of_range,
    input  logic                                i_cfg_we,
    input  logic [llds_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [llds_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import llds_pkg::*;

    // config registers
    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                REG_EXP_DOMAIN: n_cfg.exp_domain = i_cfg_data[0];
                REG_USE_DELTA:  n_cfg.use_delta  = i_cfg_data[0];
                REG_USE_WEIGHT: n_cfg.use_weight = i_cfg_data[0];
                REG_DER_ORDER:  n_cfg.order      = i_cfg_data[1:0];
            endcase
        end
    end

    // ready flag is set by the first clock edge after reset releases
    logic r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= '{use_weight: 1'b0, use_delta: 1'b0, exp_domain: 1'b0,
                         order: ORDER_TWO};
            r_ready <= 1'b0;
        end else begin
            r_cfg   <= n_cfg;
            r_ready <= 1'b1;
        end
    end

    assign o_busy = !(r_ready && i_rst_n);

    logic w_acc;
    assign w_acc = i_start && !o_busy;

    // front end: clamp, |x|, range reduction by ln2
    logic w_ser_v [SERIES_TERMS+1];
    t_ser w_ser   [SERIES_TERMS+1];

    llds_front #(
        .APPROX_WIDTH (APPROX_WIDTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_acc),
        .i_approx       (i_approx),
        .i_approx_delta (i_approx_delta),
        .i_target       (i_target),
        .i_weight       (i_weight),
        .i_last         (i_last_in_range),
        .o_valid        (w_ser_v[0]),
        .o_data         (w_ser[0])
    );

    // exp(-r) by nested series, highest term first
    for (genvar gi = 0; gi < SERIES_TERMS; gi++) begin : g_term
        llds_step #(
            .K (SERIES_TERMS - gi)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_ser_v[gi]),
            .i_data  (w_ser[gi]),
            .o_valid (w_ser_v[gi+1]),
            .o_data  (w_ser[gi+1])
        );
    end

    // p = e / (1 + e) through the pipelined divider
    logic  w_prob_v;
    t_prob w_prob;

    llds_prob u_prob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ser_v[SERIES_TERMS]),
        .i_data  (w_ser[SERIES_TERMS]),
        .o_valid (w_prob_v),
        .o_data  (w_prob)
    );

    // derivatives, weighting, saturation, output register
    llds_deriv #(
        .OUT_WIDTH (OUT_WIDTH)
    ) u_deriv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (w_prob_v),
        .i_data       (w_prob),
        .o_valid      (o_done),
        .o_first_der  (o_first_der),
        .o_second_der (o_second_der),
        .o_third_der  (o_third_der),
        .o_last       (o_last_of_range)
    );

`ifndef NO_ASSERTIONS
    // every result beat comes from an accepted input sample
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, LATENCY))
        else $error("result beat without matching input beat");

    a_order2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_cfg.order != ORDER_TWO && r_cfg.order != ORDER_THREE)
        |-> o_second_der == '0)
        else $error("second derivative not masked");

    a_order3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_cfg.order != ORDER_THREE) |-> o_third_der == '0)
        else $error("third derivative not masked");

    // -p(1-p) is never positive, weighted or not
    a_hess_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_second_der[OUT_WIDTH-1] || o_second_der == '0))
        else $error("positive second derivative");
`endif

endmodule

// ===== rtl/llds_front.sv =====
module llds_front #(
    parameter int APPROX_WIDTH = llds_pkg::APPROX_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  llds_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    input  logic signed [APPROX_WIDTH-1:0]    i_approx,
    input  logic signed [APPROX_WIDTH-1:0]    i_approx_delta,
    input  logic [llds_pkg::TARGET_W-1:0]     i_target,
    input  logic [llds_pkg::WEIGHT_W-1:0]     i_weight,
    input  logic                              i_last,
    output logic                              o_valid,
    output llds_pkg::t_ser                    o_data
);
    import llds_pkg::*;

    localparam int CW = (APPROX_WIDTH > 42) ? APPROX_WIDTH : 42;
    localparam logic signed [CW-1:0] LIM_P = CW'(42'sh0100_0000_0000);
    localparam logic signed [CW-1:0] LIM_N = -LIM_P;
    localparam logic signed [CW-1:0] EMAX  = CW'(32'sh7FFF_FFFF);

    // stage 1: clamps and log-domain sum
    logic                  r_v1;
    logic signed [X_W-1:0] r_x1;
    logic [30:0]           r_ea1, r_ed1;
    t_side                 r_side1;

    logic signed [CW-1:0]  ax, dx;
    logic signed [41:0]    ac, dc;
    logic signed [X_W-1:0] n_x1;
    logic [30:0]           n_ea1, n_ed1;
    t_side                 n_side1;

    always_comb begin
        ax = CW'(i_approx);
        dx = CW'(i_approx_delta);
        ac = 42'((ax < LIM_N) ? LIM_N : ((ax > LIM_P) ? LIM_P : ax));
        dc = 42'((dx < LIM_N) ? LIM_N : ((dx > LIM_P) ? LIM_P : dx));
        n_x1 = X_W'(ac) + (i_cfg.use_delta ? X_W'(dc) : '0);
        n_ea1 = (ax < 0) ? '0 : ((ax > EMAX) ? 31'h7FFF_FFFF : 31'(ax));
        n_ed1 = (dx < 0) ? '0 : ((dx > EMAX) ? 31'h7FFF_FFFF : 31'(dx));
        n_side1 = '0;
        n_side1.target = i_target;
        n_side1.weight = i_weight;
        n_side1.last   = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_x1    <= n_x1;
        r_ea1   <= n_ea1;
        r_ed1   <= n_ed1;
        r_side1 <= n_side1;
    end

    // stage 2: magnitude, underflow flag, exp-mode product
    logic           r_v2;
    logic [A_W-1:0] r_a2;
    t_side          r_side2;

    logic [X_W-1:0] a_full;
    t_side          n_side2;

    always_comb begin
        a_full = (r_x1 < 0) ? X_W'(-r_x1) : X_W'(r_x1);
        n_side2 = r_side1;
        n_side2.pos  = (r_x1 >= 0);
        n_side2.big  = (a_full >= BIG_LIMIT);
        n_side2.expm = i_cfg.exp_domain;
        n_side2.e    = i_cfg.use_delta ? E_W'((62'(r_ea1) * 62'(r_ed1)) >> 16)
                                       : E_W'(r_ea1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_a2    <= A_W'(a_full);
        r_side2 <= n_side2;
    end

    // stage 3: estimate of a / ln2
    logic           r_v3;
    logic [A_W-1:0] r_a3;
    logic [N_W-1:0] r_n3;
    t_side          r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_a3    <= r_a2;
        r_n3    <= N_W'((61'(r_a2) * 61'(INV_LN2)) >> INV_SHIFT);
        r_side3 <= r_side2;
    end

    // stage 4: remainder with one correction
    logic  r_v4;
    t_ser  r_d4;

    logic [36:0] rem0;
    logic        fix;
    t_ser        n_d4;

    always_comb begin
        rem0 = {r_a3, 8'h00} - 37'(r_n3) * 37'(LN2_Q32);
        fix  = (rem0 >= 37'(LN2_Q32));
        n_d4.r    = fix ? R_W'(rem0 - 37'(LN2_Q32)) : R_W'(rem0);
        n_d4.n    = r_n3 + N_W'(fix);
        n_d4.s    = ONE_Q32;
        n_d4.side = r_side3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_d4 <= n_d4;
    end

    assign o_valid = r_v4;
    assign o_data  = r_d4;

endmodule

// ===== rtl/llds_step.sv =====
module llds_step #(
    parameter int K = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  llds_pkg::t_ser i_data,
    output logic           o_valid,
    output llds_pkg::t_ser o_data
);
    import llds_pkg::*;

    // floor(2^32 / K); the estimate below is low by at most one
    localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / K);

    // s = 1 - round(r * s) / K
    logic        r_v1, r_v2, r_v3;
    t_ser        r_d1, r_d2, r_d3;
    logic [31:0] r_m1, r_m2, r_qe2;

    logic [35:0] rem;
    logic [32:0] q;
    t_ser        n_d3;

    always_comb begin
        rem = 36'(r_m2) - 36'(r_qe2) * 36'(K);
        q   = 33'(r_qe2) + 33'(rem >= 36'(K));
        n_d3 = r_d2;
        n_d3.s = ONE_Q32 - q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_d1  <= i_data;
        r_m1  <= 32'((65'(i_data.r) * 65'(i_data.s) + 65'h8000_0000) >> 32);
        r_d2  <= r_d1;
        r_m2  <= r_m1;
        r_qe2 <= 32'((65'(r_m1) * 65'(RECIP)) >> 32);
        r_d3  <= n_d3;
    end

    assign o_valid = r_v3;
    assign o_data  = r_d3;

endmodule

// ===== rtl/llds_prob.sv =====
module llds_prob (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  llds_pkg::t_ser  i_data,
    output logic            o_valid,
    output llds_pkg::t_prob o_data
);
    import llds_pkg::*;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   q;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div;

    logic r_v [Q_W+1];
    t_div r_div [Q_W+1];

    // entry: numerator and denominator of the rounded quotient
    logic [S_W-1:0]   t;
    logic [DEN_W-1:0] den;
    logic [NUM_W-1:0] num;
    t_div             n_div0;

    always_comb begin
        t = i_data.side.big ? '0 : (i_data.s >> i_data.n);
        if (i_data.side.expm) begin
            den = DEN_W'(i_data.side.e) + DEN_W'(32'h1_0000);
            num = (NUM_W'(1) << 40) + NUM_W'(den >> 1);
        end else begin
            den = DEN_W'(ONE_Q32) + DEN_W'(t);
            num = (NUM_W'(t) << 24) + NUM_W'(den >> 1);
        end
        n_div0.rem  = DEN_W'(num >> Q_W);
        n_div0.low  = num[Q_W-1:0];
        n_div0.q    = '0;
        n_div0.den  = den;
        n_div0.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_div[0] <= n_div0;
    end

    // one quotient bit per stage
    for (genvar gi = 0; gi < Q_W; gi++) begin : g_div
        logic [DEN_W:0] trial;
        logic           ge;
        t_div           n_div;

        always_comb begin
            trial = {r_div[gi].rem, r_div[gi].low[Q_W-1]};
            ge    = (trial >= {1'b0, r_div[gi].den});
            n_div = r_div[gi];
            n_div.rem = ge ? DEN_W'(trial - {1'b0, r_div[gi].den}) : DEN_W'(trial);
            n_div.low = r_div[gi].low << 1;
            n_div.q   = {r_div[gi].q[Q_W-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi+1] <= 1'b0;
            end else begin
                r_v[gi+1] <= r_v[gi];
            end
            r_div[gi+1] <= n_div;
        end
    end

    // p = 1 - q unless log mode with a negative argument
    logic  r_vp;
    t_prob r_dp;
    t_prob n_dp;

    always_comb begin
        n_dp.p = (r_div[Q_W].side.expm || r_div[Q_W].side.pos)
                 ? ONE_Q24 - P_W'(r_div[Q_W].q) : P_W'(r_div[Q_W].q);
        n_dp.target = r_div[Q_W].side.target;
        n_dp.weight = r_div[Q_W].side.weight;
        n_dp.last   = r_div[Q_W].side.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else begin
            r_vp <= r_v[Q_W];
        end
        r_dp <= n_dp;
    end

    assign o_valid = r_vp;
    assign o_data  = r_dp;

endmodule

// ===== rtl/llds_deriv.sv =====
module llds_deriv #(
    parameter int OUT_WIDTH = llds_pkg::OUT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  llds_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  llds_pkg::t_prob              i_data,
    output logic                         o_valid,
    output logic signed [OUT_WIDTH-1:0]  o_first_der,
    output logic signed [OUT_WIDTH-1:0]  o_second_der,
    output logic signed [OUT_WIDTH-1:0]  o_third_der,
    output logic                         o_last
);
    import llds_pkg::*;

    localparam int MAG_W = 26;
    localparam int WM_W  = 42;
    localparam int SW    = ((OUT_WIDTH > WM_W) ? OUT_WIDTH : WM_W) + 1;
    localparam logic [SW-1:0] MAXPOS = (SW'(1) << (OUT_WIDTH - 1)) - SW'(1);

    function automatic logic [OUT_WIDTH-1:0] sat(input logic neg,
                                                 input logic [WM_W-1:0] mag);
        logic [SW-1:0] m;
        m = SW'(mag);
        if (neg) begin
            m = (m > MAXPOS + SW'(1)) ? MAXPOS + SW'(1) : m;
            return OUT_WIDTH'(SW'(0) - m);
        end
        m = (m > MAXPOS) ? MAXPOS : m;
        return OUT_WIDTH'(m);
    endfunction

    // stage 1: d1, h = p(1-p), g = 1 - 2p
    logic                r_v1;
    logic signed [25:0]  r_d1;
    logic [22:0]         r_h1;
    logic [24:0]         r_gm1;
    logic                r_gneg1;
    logic [WEIGHT_W-1:0] r_w1;
    logic                r_last1;

    logic [P_W-1:0]     tq;
    logic [P_W-1:0]     omp;
    logic signed [26:0] g;

    always_comb begin
        tq  = {i_data.target, 8'h00};
        omp = ONE_Q24 - i_data.p;
        g   = $signed(27'(ONE_Q24)) - $signed({1'b0, i_data.p, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_d1    <= $signed({1'b0, tq}) - $signed({1'b0, i_data.p});
        r_h1    <= 23'((50'(i_data.p) * 50'(omp) + 50'h80_0000) >> 24);
        r_gm1   <= (g < 0) ? 25'(-g) : 25'(g);
        r_gneg1 <= (g < 0);
        r_w1    <= i_data.weight;
        r_last1 <= i_data.last;
    end

    // stage 2: third-order magnitude, signs, order masking
    logic                r_v2;
    logic [MAG_W-1:0]    r_mag2 [3];
    logic                r_neg2 [3];
    logic [WEIGHT_W-1:0] r_w2;
    logic                r_last2;

    logic        ord2, ord3;
    logic [22:0] m3;

    always_comb begin
        ord2 = (i_cfg.order == ORDER_TWO) || (i_cfg.order == ORDER_THREE);
        ord3 = (i_cfg.order == ORDER_THREE);
        m3   = 23'((48'(r_h1) * 48'(r_gm1) + 48'h80_0000) >> 24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_mag2[0] <= (r_d1 < 0) ? MAG_W'(-r_d1) : MAG_W'(r_d1);
        r_neg2[0] <= (r_d1 < 0);
        r_mag2[1] <= ord2 ? MAG_W'(r_h1) : '0;
        r_neg2[1] <= 1'b1;
        r_mag2[2] <= ord3 ? MAG_W'(m3) : '0;
        r_neg2[2] <= !r_gneg1;
        r_w2      <= r_w1;
        r_last2   <= r_last1;
    end

    // stage 3: weighting, round half away from zero
    logic            r_v3;
    logic [WM_W-1:0] r_mag3 [3];
    logic            r_neg3 [3];
    logic            r_last3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int i = 0; i < 3; i++) begin
            r_mag3[i] <= i_cfg.use_weight
                         ? WM_W'((58'(r_mag2[i]) * 58'(r_w2) + 58'h8000) >> 16)
                         : WM_W'(r_mag2[i]);
            r_neg3[i] <= r_neg2[i];
        end
        r_last3 <= r_last2;
    end

    // stage 4: saturate into the output register
    logic                 r_v4;
    logic [OUT_WIDTH-1:0] r_out4 [3];
    logic                 r_last4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        for (int i = 0; i < 3; i++) begin
            r_out4[i] <= sat(r_neg3[i], r_mag3[i]);
        end
        r_last4 <= r_last3;
    end

    assign o_valid      = r_v4;
    assign o_first_der  = $signed(r_out4[0]);
    assign o_second_der = $signed(r_out4[1]);
    assign o_third_der  = $signed(r_out4[2]);
    assign o_last       = r_last4;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Bench for logistic_loss_derivative_stream.
// Beats are sent on the start/busy handshake with random gaps.
// Expected derivatives are computed in an in-bench fixed-point predictor
// and queued. A monitor compares every o_done strobe with the oldest queued value.
module tb;
    import llds_pkg::*;

    localparam int        AW       = APPROX_WIDTH_DEF;
    localparam int        OW       = OUT_WIDTH_DEF;
    localparam logic [1:0] ORDER_ZERO = 2'd0;
    localparam logic [1:0] ORDER_ONE  = 2'd1;
    localparam longint    Q24      = 64'd1 << 24;
    localparam longint    Q16      = 64'd1 << 16;
    localparam longint    LN2      = 64'd2977044472;
    localparam longint    SAT_POS  = (64'd1 << (OW - 1)) - 1;
    localparam longint    Q24_23   = 64'd23 << 24;   // exp(-a) underflow point

    typedef struct packed {
        logic signed [AW-1:0] approx;
        logic signed [AW-1:0] delta;
        logic [TARGET_W-1:0]  target;
        logic [WEIGHT_W-1:0]  weight;
        logic                 last;
    } t_sample;

    typedef struct packed {
        logic [OW-1:0] d1;
        logic [OW-1:0] d2;
        logic [OW-1:0] d3;
        logic          last;
    } t_derivs;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_start;
    logic                   o_busy;
    logic signed [AW-1:0]   i_approx;
    logic signed [AW-1:0]   i_approx_delta;
    logic [TARGET_W-1:0]    i_target;
    logic [WEIGHT_W-1:0]    i_weight;
    logic                   i_last_in_range;
    logic                   o_done;
    logic signed [OW-1:0]   o_first_der;
    logic signed [OW-1:0]   o_second_der;
    logic signed [OW-1:0]   o_third_der;
    logic                   o_last_of_range;
    logic                   i_cfg_we;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // shadow copy of the config registers
    logic       sh_exp;
    logic       sh_delta;
    logic       sh_weight;
    logic [1:0] sh_order;

    t_derivs    pending_derivs[$];
    int         fail_count;

    logistic_loss_derivative_stream dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // exp(-a), a in Q.24 (non-negative), result in Q.32
    function automatic bit [63:0] exp_neg_q32(bit [63:0] a);
        bit [63:0] scaled, n, r, s, m;
        if (a >= Q24_23) return 64'd0;
        scaled = a << 8;
        n = scaled / LN2;
        r = scaled - n * LN2;
        s = 64'd1 << 32;
        for (int k = 10; k >= 1; k--) begin
            m = (r * s + (64'd1 << 31)) >> 32;
            s = (64'd1 << 32) - m / k;
        end
        return s >> n;
    endfunction

    // weight (round half away from zero), saturate, trim to output width
    function automatic logic [OW-1:0] scale_sat(longint d, bit [WEIGHT_W-1:0] w);
        longint mag;
        mag = (d < 0) ? -d : d;
        if (sh_weight) mag = (mag * longint'(w) + 64'h8000) >>> 16;
        if (d < 0) begin
            if (mag > SAT_POS + 1) mag = SAT_POS + 1;
            return OW'(-mag);
        end
        if (mag > SAT_POS) mag = SAT_POS;
        return OW'(mag);
    endfunction

    function automatic t_derivs predict_derivs(t_sample s);
        longint  av, dv, x, a, t, den, q, p, e, d1, h, g, gm, m3, d2, d3;
        t_derivs r;
        av = longint'(s.approx);
        dv = longint'(s.delta);
        if (sh_exp) begin
            // negative exp operands clamp to zero
            if (av < 0) av = 0;
            if (dv < 0) dv = 0;
            e   = sh_delta ? (av * dv) >>> 16 : av;
            den = e + Q16;
            q   = ((64'd1 << 40) + (den >>> 1)) / den;
            p   = Q24 - q;
        end else begin
            x   = sh_delta ? av + dv : av;
            a   = (x < 0) ? -x : x;
            t   = longint'(exp_neg_q32(a));
            den = (64'd1 << 32) + t;
            q   = ((t << 24) + (den >>> 1)) / den;
            p   = (x >= 0) ? Q24 - q : q;
        end
        d1 = (longint'(s.target) << 8) - p;
        h  = (p * (Q24 - p) + (64'd1 << 23)) >>> 24;
        d2 = -h;
        g  = Q24 - 2 * p;
        gm = (g < 0) ? -g : g;
        m3 = (h * gm + (64'd1 << 23)) >>> 24;
        d3 = (g >= 0) ? -m3 : m3;
        // order zero behaves as order one
        if (sh_order != ORDER_TWO && sh_order != ORDER_THREE) d2 = 0;
        if (sh_order != ORDER_THREE) d3 = 0;
        r.d1   = scale_sat(d1, s.weight);
        r.d2   = scale_sat(d2, s.weight);
        r.d3   = scale_sat(d3, s.weight);
        r.last = s.last;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result checker: o_done cannot be stalled, so every strobe is a beat
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_derivs want;
        if (i_rst_n && o_done) begin
            if (pending_derivs.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_derivs.pop_front();
                if (o_first_der !== want.d1) begin
                    $error("first_der exp %h got %h", want.d1, o_first_der);
                    fail_count++;
                end
                if (o_second_der !== want.d2) begin
                    $error("second_der exp %h got %h", want.d2, o_second_der);
                    fail_count++;
                end
                if (o_third_der !== want.d3) begin
                    $error("third_der exp %h got %h", want.d3, o_third_der);
                    fail_count++;
                end
                if (o_last_of_range !== want.last) begin
                    $error("last_of_range exp %b got %b", want.last, o_last_of_range);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // driver tasks (inputs change on the falling edge)
    // ---------------------------------------------------------------

    // drop start for a random number of cycles: mostly none, a few long
    task automatic idle_gap();
        int roll;
        int cycles;
        roll = $urandom_range(0, 99);
        if (roll < 55) cycles = 0;
        else if (roll < 93) cycles = $urandom_range(1, 3);
        else cycles = $urandom_range(10, 70);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // one beat; start stays high after acceptance so back-to-back works
    task automatic send_sample(t_sample s);
        @(negedge i_clk);
        i_start         = 1'b1;
        i_approx        = s.approx;
        i_approx_delta  = s.delta;
        i_target        = s.target;
        i_weight        = s.weight;
        i_last_in_range = s.last;
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_derivs.push_back(predict_derivs(s));
    endtask

    // wait until every queued result is out, then a little more
    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_derivs.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_EXP_DOMAIN: sh_exp    = val[0];
            REG_USE_DELTA:  sh_delta  = val[0];
            REG_USE_WEIGHT: sh_weight = val[0];
            REG_DER_ORDER:  sh_order  = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(logic e, logic d, logic w, logic [1:0] o);
        drain();
        write_reg(REG_EXP_DOMAIN, {1'b0, e});
        write_reg(REG_USE_DELTA, {1'b0, d});
        write_reg(REG_USE_WEIGHT, {1'b0, w});
        write_reg(REG_DER_ORDER, o);
    endtask

    function automatic t_sample mk(longint a, longint d, int unsigned tg,
                                   longint unsigned w, bit l);
        t_sample s;
        s.approx = AW'(a);
        s.delta  = AW'(d);
        s.target = TARGET_W'(tg);
        s.weight = WEIGHT_W'(w);
        s.last   = l;
        return s;
    endfunction

    // random sample shaped for the current mode
    function automatic t_sample rand_sample();
        t_sample s;
        int      roll;
        roll = $urandom_range(0, 9);
        s.approx = $urandom;
        s.delta  = $urandom;
        if (roll < 6) begin
            if (sh_exp) begin
                // values near 1.0 so p lands mid range
                s.approx = $urandom_range(0, 4 << 16);
                s.delta  = $urandom_range(0, 4 << 16);
            end else begin
                s.approx = $signed($urandom_range(0, 16 << 24)) - (8 << 24);
                s.delta  = $signed($urandom_range(0, 4 << 24)) - (2 << 24);
            end
        end
        roll = $urandom_range(0, 9);
        s.target = (roll < 8) ? TARGET_W'($urandom_range(0, 65536)) : TARGET_W'($urandom);
        roll = $urandom_range(0, 9);
        s.weight = (roll < 6) ? $urandom_range(0, 4 << 16) : $urandom;
        s.last   = $urandom_range(0, 1);
        return s;
    endfunction

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset defaults: log mode, no delta/weight, order two
    task automatic test_reset_defaults();
        send_sample(mk(0, 0, 32768, 0, 1'b0));
        send_sample(mk(64'sh7FFF_FFFF, 0, 65536, 0, 1'b1));
        send_sample(mk(-64'sh8000_0000, 0, 0, 0, 1'b0));
        send_sample(mk(1 << 24, -1, 65536, 32'hFFFF_FFFF, 1'b1));
    endtask

    // log mode with delta and weight, order three, extremes and huge argument
    task automatic test_log_extremes();
        set_mode(1'b0, 1'b1, 1'b1, ORDER_THREE);
        send_sample(mk(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 131071, 32'hFFFF_FFFF, 1'b1));
        send_sample(mk(-64'sh8000_0000, -64'sh8000_0000, 0, 32'hFFFF_FFFF, 1'b0));
        send_sample(mk(23 << 24, 0, 65536, 1 << 16, 1'b0));
        send_sample(mk((23 << 24) - 1, 0, 65536, 1 << 16, 1'b1));
        send_sample(mk(1 << 24, -(1 << 24), 32768, 3 << 15, 1'b0));
        send_sample(mk(-(2 << 24), 1, 131071, 32'hFFFF_FFFF, 1'b1));
    endtask

    // exp mode: negative operands clamp, multiply by delta, max values
    task automatic test_exp_mode();
        set_mode(1'b1, 1'b1, 1'b0, ORDER_THREE);
        send_sample(mk(-5, 1 << 16, 65536, 0, 1'b0));
        send_sample(mk(1 << 16, -1, 0, 0, 1'b1));
        send_sample(mk(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 65536, 0, 1'b0));
        send_sample(mk(1 << 16, 1 << 16, 32768, 0, 1'b1));
        set_mode(1'b1, 1'b0, 1'b1, ORDER_TWO);
        send_sample(mk(3 << 15, -64'sh8000_0000, 131071, 32'hFFFF_FFFF, 1'b0));
        send_sample(mk(0, 64'sh7FFF_FFFF, 0, 32'hFFFF_FFFF, 1'b1));
    endtask

    // order zero and one mask the higher derivatives
    task automatic test_orders();
        set_mode(1'b0, 1'b0, 1'b0, ORDER_ZERO);
        send_sample(mk(1 << 23, 0, 40000, 0, 1'b0));
        set_mode(1'b0, 1'b0, 1'b1, ORDER_ONE);
        send_sample(mk(-(1 << 23), 0, 40000, 5 << 16, 1'b1));
        send_sample(mk(0, 0, 131071, 32'hFFFF_FFFF, 1'b0));
    endtask

    // random phases over random settings; each phase change drains first
    task automatic test_random();
        for (int ph = 0; ph < 14; ph++) begin
            set_mode($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     2'($urandom_range(0, 3)));
            for (int i = 0; i < 100; i++) begin
                idle_gap();
                send_sample(rand_sample());
            end
        end
    endtask

    initial begin
        fail_count      = 0;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_approx        = '0;
        i_approx_delta  = '0;
        i_target        = '0;
        i_weight        = '0;
        i_last_in_range = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = REG_EXP_DOMAIN;
        i_cfg_data      = '0;
        sh_exp          = 1'b0;
        sh_delta        = 1'b0;
        sh_weight       = 1'b0;
        sh_order        = ORDER_TWO;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_log_extremes();
        test_exp_mode();
        test_orders();
        test_random();

        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (pending_derivs.size() != 0) begin
            $error("%0d results never arrived", pending_derivs.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/llds_pkg.sv
rtl/llds_front.sv
rtl/llds_step.sv
rtl/llds_prob.sv
rtl/llds_deriv.sv
rtl/logistic_loss_derivative_stream.sv
bench/tb.sv
